// File: src/ymodem_pkg.sv
// ----------------------------------------------------------------------------
// ymodem_pkg
// Shared constants, types and the CRC-16/XMODEM byte update for the YMODEM
// packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ymodem_pkg;

  localparam int LONG_BLOCK_BYTES  = 1024;
  localparam int SHORT_BLOCK_BYTES = 128;

  localparam int LEN_W = 11;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  // Start symbols
  localparam logic [7:0] SYM_SOH      = 8'h01;
  localparam logic [7:0] SYM_STX      = 8'h02;
  localparam logic [7:0] SYM_EOT      = 8'h04;
  localparam logic [7:0] SYM_CA       = 8'h18;
  localparam logic [7:0] SYM_ABORT_UP = 8'h41;
  localparam logic [7:0] SYM_ABORT_LO = 8'h61;

  // Result event codes
  localparam logic [2:0] EV_DATA     = 3'd0;
  localparam logic [2:0] EV_GOOD     = 3'd1;
  localparam logic [2:0] EV_BAD      = 3'd2;
  localparam logic [2:0] EV_EOT      = 3'd3;
  localparam logic [2:0] EV_CANCEL   = 3'd4;
  localparam logic [2:0] EV_ABORT    = 3'd5;
  localparam logic [2:0] EV_BADSTART = 3'd6;
  localparam logic [2:0] EV_TIMEOUT  = 3'd7;

  localparam logic [LEN_W-1:0] LONG_LEN   = LEN_W'(LONG_BLOCK_BYTES);
  localparam logic [LEN_W-1:0] SHORT_LEN  = LEN_W'(SHORT_BLOCK_BYTES);
  localparam logic [LEN_W-1:0] CANCEL_LEN = LEN_W'(2);

  typedef struct packed {
    logic [2:0]       event_res;
    logic [7:0]       data_byte;
    logic [7:0]       block_number;
    logic [LEN_W-1:0] payload_len;
  } result_t;

  // One byte of CRC-16/XMODEM, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/ymodem_packet_receiver_top.sv
// ----------------------------------------------------------------------------
// ymodem_packet_receiver_top
// YMODEM block framing, sequence check and CRC-16/XMODEM verification.
// ----------------------------------------------------------------------------
// Takes one received byte or timeout event per cycle and gives at most one
// result per item. Framing, the byte-wide CRC update and the verdict are
// done combinationally from the framing state registers into a two-entry
// result buffer (output register plus skid register), so input keeps
// flowing while one result waits; input stalls only when both entries are
// full. Data bytes are forwarded as they arrive: drop the block's data if
// its verdict is bad block.
`default_nettype none

module ymodem_packet_receiver_top
  import ymodem_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             timed_out,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            event_res,
  output logic [7:0]            data_byte,
  output logic [7:0]            block_number,
  output logic [LEN_W-1:0]      payload_len
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_CA   = 3'd1;
  localparam logic [2:0] PH_SEQ  = 3'd2;
  localparam logic [2:0] PH_INV  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CRCH = 3'd5;
  localparam logic [2:0] PH_CRCL = 3'd6;

  logic [2:0]       phase, phase_next;
  logic             long_block, long_block_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [7:0]       seq_value, seq_value_next;
  logic [7:0]       seq_inverse, seq_inverse_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [7:0]       trailer_hi, trailer_hi_next;

  logic             res_valid;
  result_t          res;
  logic [LEN_W-1:0] block_len;

  result_t          out_reg, skid_reg;
  logic             skid_valid;
  logic             in_xfer, out_xfer;

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  assign block_len = long_block ? LONG_LEN : SHORT_LEN;

  always_comb begin
    phase_next       = phase;
    long_block_next  = long_block;
    byte_count_next  = byte_count;
    seq_value_next   = seq_value;
    seq_inverse_next = seq_inverse;
    running_crc_next = running_crc;
    trailer_hi_next  = trailer_hi;
    res_valid        = 1'b0;
    res              = '0;

    if (timed_out) begin
      phase_next    = PH_IDLE;
      res_valid     = 1'b1;
      res.event_res = (phase == PH_CA) ? EV_BADSTART : EV_TIMEOUT;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          case (rx_byte) inside
            SYM_SOH, SYM_STX: begin
              long_block_next = (rx_byte == SYM_STX);
              byte_count_next = '0;
              phase_next      = PH_SEQ;
            end
            SYM_EOT: begin
              res_valid     = 1'b1;
              res.event_res = EV_EOT;
            end
            SYM_CA: phase_next = PH_CA;
            SYM_ABORT_UP, SYM_ABORT_LO: begin
              res_valid     = 1'b1;
              res.event_res = EV_ABORT;
            end
            default: begin
              res_valid     = 1'b1;
              res.event_res = EV_BADSTART;
            end
          endcase
        end
        PH_CA: begin
          phase_next = PH_IDLE;
          res_valid  = 1'b1;
          if (rx_byte == SYM_CA) begin
            res.event_res   = EV_CANCEL;
            res.payload_len = CANCEL_LEN;
          end else begin
            res.event_res = EV_BADSTART;
          end
        end
        PH_SEQ: begin
          seq_value_next = rx_byte;
          phase_next     = PH_INV;
        end
        PH_INV: begin
          seq_inverse_next = rx_byte;
          running_crc_next = '0;
          byte_count_next  = '0;
          phase_next       = PH_DATA;
        end
        PH_DATA: begin
          running_crc_next = crc_byte(running_crc, rx_byte);
          byte_count_next  = byte_count + LEN_W'(1);
          if (byte_count_next >= block_len) begin
            phase_next = PH_CRCH;
          end
          res_valid     = 1'b1;
          res.event_res = EV_DATA;
          res.data_byte = rx_byte;
        end
        PH_CRCH: begin
          trailer_hi_next = rx_byte;
          phase_next      = PH_CRCL;
        end
        PH_CRCL: begin
          phase_next       = PH_IDLE;
          res_valid        = 1'b1;
          res.block_number = seq_value;
          if (seq_value == ~seq_inverse && running_crc == {trailer_hi, rx_byte}) begin
            res.event_res   = EV_GOOD;
            res.payload_len = block_len;
          end else begin
            res.event_res = EV_BAD;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      long_block  <= 1'b0;
      byte_count  <= '0;
      seq_value   <= '0;
      seq_inverse <= '0;
      running_crc <= '0;
      trailer_hi  <= '0;
    end else if (in_xfer) begin
      phase       <= phase_next;
      long_block  <= long_block_next;
      byte_count  <= byte_count_next;
      seq_value   <= seq_value_next;
      seq_inverse <= seq_inverse_next;
      running_crc <= running_crc_next;
      trailer_hi  <= trailer_hi_next;
    end
  end

  // Result buffer: output register backed by one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        skid_valid <= 1'b0;
      end
    end else if (in_xfer && res_valid) begin
      if (out_valid && !out_xfer) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        out_reg <= skid_reg;
      end
    end else if (in_xfer && res_valid) begin
      if (out_valid && !out_xfer) begin
        skid_reg <= res;
      end else begin
        out_reg <= res;
      end
    end
  end

  assign event_res    = out_reg.event_res;
  assign data_byte    = out_reg.data_byte;
  assign block_number = out_reg.block_number;
  assign payload_len  = out_reg.payload_len;

endmodule

`default_nettype wire

// File: src/ymodem_checker.sv
// ----------------------------------------------------------------------------
// ymodem_checker
// Port-level checks on the YMODEM packet receiver results.
// ----------------------------------------------------------------------------
`default_nettype none

module ymodem_checker
  import ymodem_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [2:0]       event_res,
  input wire logic [7:0]       data_byte,
  input wire logic [7:0]       block_number,
  input wire logic [LEN_W-1:0] payload_len
);

  // A stalled result must hold until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(data_byte)
      && $stable(block_number) && $stable(payload_len))
    else $error("stalled result changed");

  // Input only stalls while a result is waiting
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_data_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_DATA |-> data_byte == 8'h00)
    else $error("data byte on a non-data event");

  a_block_num: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_GOOD && event_res != EV_BAD |-> block_number == 8'h00)
    else $error("block number outside a verdict");

  a_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (event_res == EV_GOOD && (payload_len == LONG_LEN || payload_len == SHORT_LEN)) ||
      (event_res == EV_CANCEL && payload_len == CANCEL_LEN) ||
      (event_res != EV_GOOD && event_res != EV_CANCEL && payload_len == '0))
    else $error("payload length does not fit the event");

endmodule

bind ymodem_packet_receiver_top ymodem_checker u_ymodem_checker (.*);

`default_nettype wire
